// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the record loader RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- sv/hexl_pkg.sv -----
// ----------------------------------------------------------------------------
// hexl_pkg
// Types and constants shared by the hex record loader modules.
// ----------------------------------------------------------------------------
package hexl_pkg;

  localparam int unsigned PosW = 10;
  localparam logic [PosW-1:0] POS_MAX = 10'd1023;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] REC_DATA = 8'h00;
  localparam logic [7:0] REC_END  = 8'h01;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_END      = 3'd1,
    ST_BAD_SUM  = 3'd2,
    ST_BAD_FMT  = 3'd3,
    ST_BAD_TYPE = 3'd4
  } status_e;

  typedef struct packed {
    logic       is_space;
    logic       is_colon;
    logic       is_hex;
    logic [3:0] nibble;
  } char_class_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] address;
    logic [7:0]  data_byte;
    status_e     status;
  } result_t;

endpackage

// ----- sv/hexl_char_class.sv -----
// ----------------------------------------------------------------------------
// hexl_char_class
// Classifies one ASCII character: whitespace, colon, hex digit and its value.
// ----------------------------------------------------------------------------
module hexl_char_class import hexl_pkg::*; (
  input  logic [7:0]  ch_i,
  output char_class_t cls_o
);

  always_comb begin
    cls_o.is_space = ((ch_i >= 8'd9) && (ch_i <= 8'd13)) || (ch_i == 8'd32);
    cls_o.is_colon = (ch_i == CH_COLON);
    cls_o.is_hex   = 1'b1;
    cls_o.nibble   = 4'd0;
    if ((ch_i >= 8'h30) && (ch_i <= 8'h39)) begin
      cls_o.nibble = ch_i[3:0];
    end else if (((ch_i >= 8'h61) && (ch_i <= 8'h66)) ||
                 ((ch_i >= 8'h41) && (ch_i <= 8'h46))) begin
      // 'a'..'f' and 'A'..'F' share the low three bits: 1..6
      cls_o.nibble = 4'(ch_i[2:0]) + 4'd9;
    end else begin
      cls_o.is_hex = 1'b0;
    end
  end

endmodule

// ----- sv/hexl_parser.sv -----
// ----------------------------------------------------------------------------
// hexl_parser
// Record state machine: token position, header fields, checksum and the
// result produced by each accepted character.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hexl_parser import hexl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  char_class_t cls_i,
  output logic        res_valid_o,
  output result_t     res_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      len_q, len_d;
  logic [15:0]     addr_q, addr_d;
  logic [7:0]      rtype_q, rtype_d;
  logic [7:0]      sum_q, sum_d;
  logic [3:0]      nib_q, nib_d;
  logic            fmt_q, fmt_d;
  logic            done_q, done_d;

  logic [PosW-1:0] exp_len;
  logic [PosW-1:0] last_hi;
  logic [8:0]      bidx;
  logic [8:0]      blim;
  logic [7:0]      byte_val;

  assign exp_len  = 10'd11 + {1'b0, len_q, 1'b0};
  assign last_hi  = 10'd10 + {1'b0, len_q, 1'b0};
  assign bidx     = pos_q[PosW-1:1] - 9'd1;
  assign blim     = {1'b0, len_q} + 9'd4;
  assign byte_val = {nib_q, cls_i.nibble};

  always_comb begin
    pos_d       = pos_q;
    len_d       = len_q;
    addr_d      = addr_q;
    rtype_d     = rtype_q;
    sum_d       = sum_q;
    nib_d       = nib_q;
    fmt_d       = fmt_q;
    done_d      = done_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_VERDICT, address: addr_q, data_byte: len_q, status: ST_OK};

    if (!done_q) begin
      if (cls_i.is_space) begin
        if (pos_q != '0) begin
          res_valid_o = 1'b1;
          pos_d       = '0;
          if (fmt_q || (pos_q != exp_len)) begin
            res_o.status = ST_BAD_FMT;
          end else if (sum_q != 8'd0) begin
            res_o.status = ST_BAD_SUM;
          end else if (rtype_q == REC_DATA) begin
            res_o.status = ST_OK;
          end else if (rtype_q == REC_END) begin
            res_o.status = ST_END;
            done_d       = 1'b1;
          end else begin
            res_o.status = ST_BAD_TYPE;
          end
        end
      end else if (pos_q == '0) begin
        // first character of a token
        len_d   = '0;
        addr_d  = '0;
        rtype_d = '0;
        sum_d   = '0;
        nib_d   = '0;
        fmt_d   = !cls_i.is_colon;
        pos_d   = 10'd1;
      end else begin
        if (pos_q != POS_MAX) pos_d = pos_q + 10'd1;
        if (!fmt_q) begin
          if (!cls_i.is_hex) begin
            fmt_d = 1'b1;
          end else if (pos_q[0]) begin
            nib_d = cls_i.nibble;
            if ((pos_q >= 10'd3) && (pos_q > last_hi)) fmt_d = 1'b1;
          end else if ((bidx >= 9'd4) && (bidx > blim)) begin
            fmt_d = 1'b1;
          end else begin
            sum_d = sum_q + byte_val;
            case (bidx)
              9'd0: len_d = byte_val;
              9'd1: addr_d = {byte_val, 8'd0};
              9'd2: addr_d = {addr_q[15:8], byte_val};
              9'd3: rtype_d = byte_val;
              default: begin
                if (bidx < blim) begin
                  res_valid_o = 1'b1;
                  res_o = '{kind: KIND_DATA,
                            address: addr_q + 16'(bidx - 9'd4),
                            data_byte: byte_val,
                            status: ST_OK};
                end
              end
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      len_q   <= '0;
      addr_q  <= '0;
      rtype_q <= '0;
      sum_q   <= '0;
      nib_q   <= '0;
      fmt_q   <= 1'b0;
      done_q  <= 1'b0;
    end else if (en_i) begin
      pos_q   <= pos_d;
      len_q   <= len_d;
      addr_q  <= addr_d;
      rtype_q <= rtype_d;
      sum_q   <= sum_d;
      nib_q   <= nib_d;
      fmt_q   <= fmt_d;
      done_q  <= done_d;
    end
  end

  `ASSERT_CLK(a_done_sticky, clk_i, rst_ni, done_q |=> done_q, "end state left")
  `ASSERT_CLK(a_done_quiet, clk_i, rst_ni, done_q |-> !res_valid_o, "result after end record")
  `ASSERT_CLK(a_end_sets_done, clk_i, rst_ni,
    (en_i && res_valid_o && (res_o.kind == KIND_VERDICT) && (res_o.status == ST_END)) |=> done_q,
    "end verdict did not stop loading")

endmodule

// ----- sv/intel_hex_record_loader.sv -----
// ----------------------------------------------------------------------------
// intel_hex_record_loader
// Parses Intel HEX text, one character per transfer, into data bytes with
// addresses and one verdict per record.
// A result is registered on the transfer of the character that causes it.
// Throughput: 1 character per cycle; input stalls only while a result waits.
// Reset: asynchronous, active low; clears token state and the end flag.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module intel_hex_record_loader import hexl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        ch_valid_i,
  output logic        ch_ready_o,
  input  logic [7:0]  ch_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [15:0] address_o,
  output logic [7:0]  data_byte_o,
  output logic [2:0]  status_o
);

  char_class_t cls;
  logic        in_fire;
  logic        res_valid;
  result_t     res;
  logic        out_valid_q;
  result_t     out_q;

  assign ch_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = ch_valid_i && ch_ready_o;

  hexl_char_class u_class (
    .ch_i  (ch_i),
    .cls_o (cls)
  );

  hexl_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (in_fire),
    .cls_i       (cls),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= res_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_q.kind;
  assign address_o   = out_q.address;
  assign data_byte_o = out_q.data_byte;
  assign status_o    = out_q.status;

  `ASSERT_NEVER(a_no_take_when_full, clk_i, rst_ni,
    out_valid_q && !out_ready_i && in_fire, "transfer accepted over a held result")
  `ASSERT_CLK(a_data_status_ok, clk_i, rst_ni,
    (out_valid_q && (out_q.kind == KIND_DATA)) |-> (out_q.status == ST_OK),
    "data byte with nonzero status")

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Intel HEX record loader. Drives hex text one
// character per transfer, with a short table of hand-picked tokens first and
// then random records, broken records and noise. A local parser model
// predicts every data byte and each verdict not given by a typed row; outputs are compared in order.
// ----------------------------------------------------------------------------
module tb;
  import hexl_pkg::*;

  localparam int RAND_ITEMS  = 1150;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    string   text;
    bit      typed;
    result_t verdict;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        ch_valid_i = 1'b0;
  logic        ch_ready_o;
  logic [7:0]  ch_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        kind_o;
  logic [15:0] address_o;
  logic [7:0]  data_byte_o;
  logic [2:0]  status_o;

  // parser model state
  logic [9:0]  tok_pos;
  logic [7:0]  rec_len;
  logic [15:0] rec_addr;
  logic [7:0]  rec_type;
  logic [7:0]  rec_sum;
  logic [3:0]  hi_nib;
  bit          fmt_bad;
  bit          load_done;

  result_t parsed_q[$];
  int      errors = 0;
  int      n_sent = 0;
  int      cycle_count = 0;
  bit      quiet_run = 1'b0;

  logic [7:0] space_chars [6] = '{8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd32};
  string      bad_chars = "GHXYZghxyz:-./!~";

  // The expected verdict of every typed row is readable from its text.
  row_t dir_rows [10] = '{
    '{"\t\v\f \015", 1'b0, '{KIND_DATA, 16'h0000, 8'h00, ST_OK}},
    '{"x\n", 1'b1, '{KIND_VERDICT, 16'h0000, 8'h00, ST_BAD_FMT}},
    '{":0000000000 ", 1'b1, '{KIND_VERDICT, 16'h0000, 8'h00, ST_OK}},
    '{":02FFFF00ABcd88\t", 1'b1, '{KIND_VERDICT, 16'hFFFF, 8'h02, ST_OK}},
    '{":0000000001\n", 1'b1, '{KIND_VERDICT, 16'h0000, 8'h00, ST_BAD_SUM}},
    '{":00123402B8 ", 1'b1, '{KIND_VERDICT, 16'h1234, 8'h00, ST_BAD_TYPE}},
    '{":0112G\n", 1'b1, '{KIND_VERDICT, 16'h1200, 8'h01, ST_BAD_FMT}},
    '{":0100000000 ", 1'b1, '{KIND_VERDICT, 16'h0000, 8'h01, ST_BAD_FMT}},
    '{":0000000000FF\v", 1'b1, '{KIND_VERDICT, 16'h0000, 8'h00, ST_BAD_FMT}},
    '{"\377\015", 1'b1, '{KIND_VERDICT, 16'h0000, 8'h00, ST_BAD_FMT}}
  };

  intel_hex_record_loader i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ch_valid_i  (ch_valid_i),
    .ch_ready_o  (ch_ready_o),
    .ch_i        (ch_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .address_o   (address_o),
    .data_byte_o (data_byte_o),
    .status_o    (status_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void parse_char(input logic [7:0] c, output bit got, output result_t r);
    int         p;
    int         b;
    int         nib;
    logic [7:0] val;
    status_e    st;
    got = 1'b0;
    r = '{KIND_DATA, 16'h0000, 8'h00, ST_OK};
    if (load_done) return;
    if ((c >= 8'd9 && c <= 8'd13) || c == 8'd32) begin
      if (tok_pos == 0) return;
      if (fmt_bad || int'(tok_pos) != 11 + 2 * int'(rec_len)) st = ST_BAD_FMT;
      else if (rec_sum != 8'h00) st = ST_BAD_SUM;
      else if (rec_type == REC_DATA) st = ST_OK;
      else if (rec_type == REC_END) begin
        st = ST_END;
        load_done = 1'b1;
      end else st = ST_BAD_TYPE;
      r = '{KIND_VERDICT, rec_addr, rec_len, st};
      got = 1'b1;
      tok_pos = '0;
      return;
    end
    if (tok_pos == 0) begin
      rec_len = '0;
      rec_addr = '0;
      rec_type = '0;
      rec_sum = '0;
      hi_nib = '0;
      fmt_bad = (c != CH_COLON);
      tok_pos = 10'd1;
      return;
    end
    p = int'(tok_pos);
    if (tok_pos < POS_MAX) tok_pos++;
    if (fmt_bad) return;
    if (c >= "0" && c <= "9") nib = int'(c) - "0";
    else if (c >= "a" && c <= "f") nib = int'(c) - "a" + 10;
    else if (c >= "A" && c <= "F") nib = int'(c) - "A" + 10;
    else begin
      fmt_bad = 1'b1;
      return;
    end
    if (p % 2 == 1) begin
      hi_nib = 4'(nib);
      // first digit past the checksum
      if (p >= 3 && p > 10 + 2 * int'(rec_len)) fmt_bad = 1'b1;
      return;
    end
    val = {hi_nib, 4'(nib)};
    b = (p - 2) / 2;
    if (b >= 4 && b > 4 + int'(rec_len)) begin
      fmt_bad = 1'b1;
      return;
    end
    rec_sum += val;
    if (b == 0) rec_len = val;
    else if (b == 1) rec_addr = {val, 8'h00};
    else if (b == 2) rec_addr[7:0] = val;
    else if (b == 3) rec_type = val;
    else if (b < 4 + int'(rec_len)) begin
      r = '{KIND_DATA, rec_addr + 16'(b - 4), val, ST_OK};
      got = 1'b1;
    end
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  function automatic void push_byte(ref logic [7:0] tok[$], input logic [7:0] v);
    tok.push_back(hex_char(v[7:4]));
    tok.push_back(hex_char(v[3:0]));
  endfunction

  // An end record with a good checksum would lock the block, so its sum is
  // always spoiled here; the real one is sent last.
  function automatic void build_record(ref logic [7:0] tok[$], input int declared,
                                       input int count, input logic [7:0] rtype,
                                       input logic [15:0] addr, input bit sum_good);
    logic [7:0] sum;
    logic [7:0] b;
    tok.delete();
    tok.push_back(CH_COLON);
    sum = 8'(declared) + addr[15:8] + addr[7:0] + rtype;
    push_byte(tok, 8'(declared));
    push_byte(tok, addr[15:8]);
    push_byte(tok, addr[7:0]);
    push_byte(tok, rtype);
    repeat (count) begin
      b = 8'($urandom);
      sum += b;
      push_byte(tok, b);
    end
    b = 8'(-sum);
    if (!sum_good || rtype == REC_END) b += 8'($urandom_range(1, 255));
    push_byte(tok, b);
  endfunction

  task automatic send_char(input logic [7:0] c, input bit typed, input result_t verdict);
    int      idle;
    bit      got;
    result_t r;
    idle = 0;
    if (!quiet_run) while ($urandom_range(99) < 13) idle++;
    if (idle > 0) begin
      ch_valid_i <= 1'b0;
      repeat (idle) @(negedge clk_i);
    end
    ch_valid_i <= 1'b1;
    ch_i <= c;
    do @(posedge clk_i); while (!ch_ready_o);
    parse_char(c, got, r);
    if (typed) begin
      got = 1'b1;
      r = verdict;
    end
    if (got) parsed_q.push_back(r);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    ch_valid_i <= 1'b0;
    do @(negedge clk_i); while (parsed_q.size() != 0);
  endtask

  task automatic send_row(input row_t row);
    for (int i = 0; i < row.text.len(); i++) begin
      send_char(row.text[i], row.typed && i == row.text.len() - 1, row.verdict);
    end
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= quiet_run || ($urandom_range(99) >= 13);
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin : check_out
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (parsed_q.size() == 0) begin
        $error("unexpected result: kind %0d address 0x%0h byte 0x%0h status %0d",
               kind_o, address_o, data_byte_o, status_o);
        errors++;
      end else begin
        want = parsed_q.pop_front();
        check_field("kind", want.kind, kind_o);
        check_field("address", want.address, address_o);
        check_field("data_byte", want.data_byte, data_byte_o);
        check_field("status", want.status, status_o);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [7:0]  tok[$];
    logic [7:0]  rtype;
    logic [7:0]  junk;
    logic [15:0] addr;
    int          pick;
    int          count;
    int          pos;
    row_t        end_rows [2];

    tok_pos = '0;
    rec_len = '0;
    rec_addr = '0;
    rec_type = '0;
    rec_sum = '0;
    hi_nib = '0;
    fmt_bad = 1'b0;
    load_done = 1'b0;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) send_row(dir_rows[i]);

    while (n_sent < RAND_ITEMS) begin
      quiet_run = (n_sent >= 400 && n_sent < 700);
      pick = $urandom_range(99);
      count = ($urandom_range(99) == 0) ? 255 : $urandom_range(0, 8);
      addr = ($urandom_range(7) == 0) ? 16'hFFFF - 16'($urandom_range(3)) : 16'($urandom);
      case ($urandom_range(9))
        7, 8:    rtype = REC_END;
        9:       rtype = 8'($urandom_range(2, 255));
        default: rtype = REC_DATA;
      endcase
      if (pick < 70) begin
        build_record(tok, count, count, rtype, addr, $urandom_range(15) != 0);
      end else if (pick < 85) begin
        // a wrong length on an end record could be cut back into a valid one
        build_record(tok, ($urandom_range(3) == 0 && rtype != REC_END) ?
                     $urandom_range(255) : count,
                     count, rtype, addr, 1'b1);
        case ($urandom_range(3))
          0: tok = tok[0:$urandom_range(1, tok.size() - 1) - 1];
          1: begin
            pos = $urandom_range(1, tok.size() - 1);
            tok.insert(pos, bad_chars[$urandom_range(bad_chars.len() - 1)]);
          end
          2: repeat ($urandom_range(1, 3)) tok.push_back(hex_char(4'($urandom)));
          default: begin
            do junk = 8'($urandom_range(33, 126)); while (junk == CH_COLON);
            tok[0] = junk;
          end
        endcase
      end else begin
        tok.delete();
        repeat ($urandom_range(1, 6)) tok.push_back(8'($urandom_range(0, 255)));
      end
      foreach (tok[i]) send_char(tok[i], 1'b0, '{KIND_DATA, 16'h0, 8'h0, ST_OK});
      repeat ($urandom_range(1, 3)) begin
        send_char(space_chars[$urandom_range(5)], 1'b0, '{KIND_DATA, 16'h0, 8'h0, ST_OK});
      end
      if ($urandom_range(29) == 0) wait_drained();
    end
    quiet_run = 1'b0;
    wait_drained();

    // end record, then text that must be ignored
    end_rows[0] = '{":00000001FF\n", 1'b1, '{KIND_VERDICT, 16'h0000, 8'h00, ST_END}};
    end_rows[1] = '{":00000000 00\nx :0000000000 ", 1'b0, '{KIND_DATA, 16'h0, 8'h0, ST_OK}};
    foreach (end_rows[i]) send_row(end_rows[i]);

    wait_drained();
    repeat (20) @(negedge clk_i);
    if (errors == 0 && parsed_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
